FILE: hw/rtl/cpt_pkg.sv
// Shared types and constants of the capture-period tachometer.
package cpt_pkg;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_OVERFLOW = 2'd0,
    ACT_CAPTURE  = 2'd1,
    ACT_STOP     = 2'd2,
    ACT_ACK      = 2'd3
  } cpt_action_t;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_TICKS_PER_US   = 2'd0;
  localparam logic [1:0] REG_PULSES_PER_REV = 2'd1;
  localparam logic [1:0] REG_STOP_LIMIT     = 2'd2;

  // Register reset values
  localparam logic [7:0]  TICKS_PER_US_RST   = 8'd32;
  localparam logic [7:0]  PULSES_PER_REV_RST = 8'd5;
  localparam logic [15:0] STOP_LIMIT_RST     = 16'd20;

  // Divider geometry
  localparam int DIV_W    = 32;
  localparam int STEP_W   = 6;
  localparam int RPM_NUM_W = 26;

  // 60e6 us per minute, left-aligned in the dividend so 26 steps give the quotient
  localparam logic [DIV_W-1:0] RPM_NUM      = 32'd60000000;
  localparam logic [DIV_W-1:0] RPM_DIVIDEND = RPM_NUM << (DIV_W - RPM_NUM_W);
  localparam logic [STEP_W-1:0] STEPS_FULL  = STEP_W'(DIV_W);
  localparam logic [STEP_W-1:0] STEPS_RPM   = STEP_W'(RPM_NUM_W);

  localparam logic [15:0] SPEED_MAX = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } cpt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } cpt_div_rsp_t;

endpackage

FILE: hw/rtl/cpt_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module cpt_divider
  import cpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cpt_div_req_t req,
  output cpt_div_rsp_t rsp
);

  logic [STEP_W-1:0] count;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dq;
  logic [DIV_W-1:0]  dvsr;
  logic              done;
  logic [DIV_W:0]    trial;

  // Trial subtraction of the divisor from the shifted partial remainder
  assign trial = {rem, dq[DIV_W-1]} - {1'b0, dvsr};

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (req.start) begin
      count <= req.steps;
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - STEP_W'(1);
      done  <= (count == STEP_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      dq   <= req.dividend;
      dvsr <= req.divisor;
    end else if (count != '0) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-2:0], dq[DIV_W-1]};
        dq  <= {dq[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

FILE: hw/rtl/capture_period_tachometer_unit.sv
// Top level of the capture-period tachometer: event handling, sequencer, ports.
//
// Input stream: one transfer per event. s_tuser carries the event kind
// (overflow, capture, stop tick, acknowledge), s_tdata the captured count.
// Output stream: exactly one result transfer per input transfer, carrying
// the speed in rpm and the new_measurement, stopped and done flags.
// Overflows, stop ticks, acknowledges and first captures pass from idle
// straight to the emit state, which loads the output register once it is
// free and returns to idle. A second capture runs the period division
// (32 steps), one multiply, a range check and the rpm division (26 steps)
// on a single shared divider, then emits; when the range check settles
// the speed alone, the rpm division is skipped.
// One event is handled at a time; s_tready is high only while idle.
// The result sits in an output register; if the receiver stalls, one more
// event can be taken and worked on, and its result then waits with
// s_tready low until the pending result is taken.
// Reset clears all measurement state and loads the register defaults
// (ticks_per_us 32, pulses_per_rev 5, stop_limit 20).
// Registers on the APB port: 0x0 ticks_per_us, 0x4 pulses_per_rev,
// 0x8 stop_limit; write them only while the block is idle.
module capture_period_tachometer_unit
  import cpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_value
  input  logic [1:0]  s_tuser,   // [1:0] action
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] speed
  output logic [2:0]  m_tuser,   // [0] new_measurement, [1] stopped, [2] done_flag
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV_T = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_CHK   = 6'b001000,
    ST_DIV_S = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [7:0]  ticks_per_us;
  logic [7:0]  pulses_per_rev;
  logic [15:0] stop_limit;

  logic        armed;
  logic        done;
  logic [15:0] first_count;
  logic [15:0] overflow_count;
  logic [15:0] stop_count;
  logic [15:0] speed_value;
  logic        newm;
  logic        stp;
  logic [39:0] denom;

  cpt_div_req_t div_req;
  cpt_div_rsp_t div_rsp;

  cpt_action_t action;
  logic        accept;
  logic        out_free;
  logic [31:0] raw;
  logic [15:0] stop_inc;
  logic [7:0]  div_tpu;
  logic [7:0]  div_ppr;

  assign action   = cpt_action_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign pready   = 1'b1;

  // Zero divisor registers act as one
  assign div_tpu = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
  assign div_ppr = (pulses_per_rev == 8'd0) ? 8'd1 : pulses_per_rev;

  // Raw tick span, wraps mod 2^32
  assign raw = {overflow_count, 16'h0000} + {16'h0000, s_tdata} - {16'h0000, first_count};

  assign stop_inc = (stop_count == COUNT_MAX) ? stop_count : stop_count + 16'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us   <= TICKS_PER_US_RST;
      pulses_per_rev <= PULSES_PER_REV_RST;
      stop_limit     <= STOP_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_TICKS_PER_US:   ticks_per_us   <= pwdata[7:0];
        REG_PULSES_PER_REV: pulses_per_rev <= pwdata[7:0];
        REG_STOP_LIMIT:     stop_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      REG_TICKS_PER_US:   prdata = {24'h0, ticks_per_us};
      REG_PULSES_PER_REV: prdata = {24'h0, pulses_per_rev};
      REG_STOP_LIMIT:     prdata = {16'h0, stop_limit};
      default:            prdata = 32'h0;
    endcase
  end

  // Divider launch: period on a second capture, rpm when the range check passes
  always_comb begin
    div_req = '0;
    if (accept && action == ACT_CAPTURE && armed) begin
      div_req.start    = 1'b1;
      div_req.dividend = raw;
      div_req.divisor  = {24'h0, div_tpu};
      div_req.steps    = STEPS_FULL;
    end else if (state == ST_CHK && denom != '0 && denom <= {8'h0, RPM_NUM}) begin
      div_req.start    = 1'b1;
      div_req.dividend = RPM_DIVIDEND;
      div_req.divisor  = denom[31:0];
      div_req.steps    = STEPS_RPM;
    end
  end

  cpt_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_CAPTURE && armed) ? ST_DIV_T : ST_EMIT;
        end
      end
      ST_DIV_T: if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:   state_next = ST_CHK;
      ST_CHK:   state_next = div_req.start ? ST_DIV_S : ST_EMIT;
      ST_DIV_S: if (div_rsp.done) state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Period times pulses per revolution
  always_ff @(posedge clk) begin
    if (state == ST_MUL) denom <= {8'h00, div_rsp.quotient} * {32'h0, div_ppr};
  end

  // Measurement state and per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      done           <= 1'b0;
      first_count    <= '0;
      overflow_count <= '0;
      stop_count     <= '0;
      speed_value    <= '0;
      newm           <= 1'b0;
      stp            <= 1'b0;
    end else if (accept) begin
      newm <= 1'b0;
      stp  <= 1'b0;
      case (action)
        ACT_OVERFLOW: begin
          if (armed && overflow_count != COUNT_MAX)
            overflow_count <= overflow_count + 16'd1;
        end
        ACT_CAPTURE: begin
          overflow_count <= '0;
          if (armed) begin
            stop_count <= '0;
            done       <= 1'b1;
            armed      <= 1'b0;
            newm       <= 1'b1;
          end else begin
            first_count <= s_tdata;
            armed       <= 1'b1;
            done        <= 1'b0;
          end
        end
        ACT_STOP: begin
          if (stop_inc >= stop_limit) begin
            speed_value <= '0;
            stop_count  <= '0;
            stp         <= 1'b1;
          end else begin
            stop_count <= stop_inc;
          end
        end
        ACT_ACK:  done <= 1'b0;
        default: ;
      endcase
    end else if (state == ST_CHK && !div_req.start) begin
      // Zero denominator saturates; period times pulses beyond the numerator gives zero
      speed_value <= (denom == '0) ? SPEED_MAX : 16'h0000;
    end else if (state == ST_DIV_S && div_rsp.done) begin
      speed_value <= (div_rsp.quotient > {16'h0, SPEED_MAX}) ?
                     SPEED_MAX : div_rsp.quotient[15:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= speed_value;
      m_tuser <= {done, stp, newm};
    end
  end

endmodule
